// ----- hdl/stlb_pkg.sv -----
package stlb_pkg;

  // Fixed field widths
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned TAG_W  = 24;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned LPS_W  = 5;

  // Page shift limits and the reset page size
  localparam logic [LPS_W-1:0] LPS_MIN   = 5'd8;
  localparam logic [LPS_W-1:0] LPS_MAX   = 5'd16;
  localparam logic [LPS_W-1:0] LPS_RESET = 5'd12;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [LPS_W-1:0]  lps_t;

  typedef enum logic [1:0] {
    OP_LOOKUP     = 2'd0,
    OP_FILL       = 2'd1,
    OP_FLUSH_PAGE = 2'd2,
    OP_FLUSH_ALL  = 2'd3
  } op_e;

endpackage

// ----- hdl/stlb_req_if.sv -----
interface stlb_req_if;
  import stlb_pkg::*;

  logic  valid;
  logic  ready;
  op_e   operation;
  addr_t virtual_address;
  addr_t physical_page;

  modport source (
    output valid, operation, virtual_address, physical_page,
    input  ready
  );

  modport sink (
    input  valid, operation, virtual_address, physical_page,
    output ready
  );

endinterface

// ----- hdl/stlb_rsp_if.sv -----
interface stlb_rsp_if;
  import stlb_pkg::*;

  logic  valid;
  logic  ready;
  logic  hit;
  addr_t translation;
  cnt_t  hits_so_far;
  cnt_t  misses_so_far;
  cnt_t  flushes_so_far;

  modport source (
    output valid, hit, translation, hits_so_far, misses_so_far, flushes_so_far,
    input  ready
  );

  modport sink (
    input  valid, hit, translation, hits_so_far, misses_so_far, flushes_so_far,
    output ready
  );

endinterface

// ----- hdl/set_associative_tlb_lru.sv -----
// Set-associative TLB with true LRU replacement, 2**LOG_SETS sets of WAYS ways.
// Every request transaction (lookup, fill, flush one page, flush all) yields one
// response transaction, registered after stage 1; requests are taken every
// cycle unless the response stalls, a full flush sits in stage 1 or the
// clearing pass runs. The set's row is read from the entry memories in the
// accept cycle and resolved, updated and written back in stage 1 as it
// advances; a row written by the previous transaction is forwarded. A full
// flush clears the valid bits with this pass over the memories, one set per
// cycle, holding off the request side until it ends. The same pass runs after
// reset, also restoring the LRU order. log_page_size is taken saturated to
// 8..16 and must only be written while the block is idle.
module set_associative_tlb_lru #(
  parameter int unsigned LOG_SETS = 4,
  parameter int unsigned WAYS     = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [stlb_pkg::LPS_W-1:0] cfg_wdata_i,
  stlb_req_if.sink              req_i,
  stlb_rsp_if.source            rsp_o
);
  import stlb_pkg::*;

  localparam int unsigned SETS   = 1 << LOG_SETS;
  localparam int unsigned SET_IW = (LOG_SETS > 0) ? LOG_SETS : 1;
  localparam int unsigned WIDX   = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  typedef logic [SET_IW-1:0]           set_t;
  typedef logic [WIDX-1:0]             way_t;
  typedef logic [WAYS-1:0]             vld_row_t;
  typedef logic [WAYS-1:0][TAG_W-1:0]  tag_row_t;
  typedef logic [WAYS-1:0][ADDR_W-1:0] frm_row_t;
  typedef logic [WAYS-1:0][WIDX-1:0]   ord_row_t;

  // Entry memories, one row per set
  vld_row_t vld_mem [SETS];
  tag_row_t tag_mem [SETS];
  frm_row_t frm_mem [SETS];
  ord_row_t ord_mem [SETS];

  // Config and control state
  lps_t  lps_q;
  logic  state_q, state_d;
  logic  clr_ord_q, clr_ord_d;
  set_t  swp_idx_q, swp_idx_d;
  logic  s1_valid_q;
  logic  rsp_valid_q;
  cnt_t  hit_cnt_q, miss_cnt_q, flush_cnt_q;
  cnt_t  hit_cnt_d, miss_cnt_d, flush_cnt_d;

  // Stage 1 payload
  op_e      s1_op_q;
  set_t     s1_set_q;
  tag_t     s1_tag_q;
  addr_t    s1_pp_q;
  logic     byp_q;
  vld_row_t rd_vld_q, byp_vld_q;
  tag_row_t rd_tag_q, byp_tag_q;
  frm_row_t rd_frm_q, byp_frm_q;
  ord_row_t rd_ord_q, byp_ord_q;

  // Response payload
  logic  rsp_hit_q;
  addr_t rsp_trans_q;

  logic  accept, s1_adv;
  lps_t  shamt;
  addr_t page_in;
  set_t  set_in;

  // Memory write port
  logic     wr_row_en, wr_vld_en, wr_ord_en;
  set_t     wr_set;
  vld_row_t wr_vld;
  tag_row_t wr_tag;
  frm_row_t wr_frm;
  ord_row_t wr_ord;
  ord_row_t ord_init;

  // Stage 1 resolution
  vld_row_t row_vld, new_vld;
  tag_row_t row_tag, new_tag;
  frm_row_t row_frm, new_frm;
  ord_row_t row_ord, new_ord, rec_ord;
  logic     hit_any, inv_any, touch;
  way_t     hit_way, inv_way, victim, touch_way, pos;
  logic     res_hit;
  addr_t    res_trans;

  // Handshake
  assign s1_adv = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = (state_q == ST_RUN) &&
                       (!s1_valid_q || (s1_adv && s1_op_q != OP_FLUSH_ALL));
  assign accept = req_i.valid && req_i.ready;

  // Saturate the page shift and pick the set of the incoming address
  always_comb begin
    shamt = lps_q;
    if (lps_q < LPS_MIN) shamt = LPS_MIN;
    if (lps_q > LPS_MAX) shamt = LPS_MAX;
  end
  assign page_in = req_i.virtual_address >> shamt;
  assign set_in  = SET_IW'(page_in & ADDR_W'(SETS - 1));

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lps_q <= LPS_RESET;
    end else if (cfg_we_i) begin
      lps_q <= cfg_wdata_i;
    end
  end

  // Initial LRU order: way 0 most recent
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      ord_init[i] = WIDX'(i);
    end
  end

  // Write port: row update from stage 1, or the clearing pass
  always_comb begin
    wr_row_en = s1_adv && (s1_op_q != OP_FLUSH_ALL);
    wr_vld_en = wr_row_en || (state_q == ST_SWEEP);
    wr_ord_en = wr_row_en || (state_q == ST_SWEEP && clr_ord_q);
    wr_set    = (state_q == ST_SWEEP) ? swp_idx_q : s1_set_q;
    wr_vld    = (state_q == ST_SWEEP) ? '0 : new_vld;
    wr_ord    = (state_q == ST_SWEEP) ? ord_init : new_ord;
    wr_tag    = new_tag;
    wr_frm    = new_frm;
  end

  always_ff @(posedge clk_i) begin
    if (wr_vld_en) vld_mem[wr_set] <= wr_vld;
    if (wr_ord_en) ord_mem[wr_set] <= wr_ord;
    if (wr_row_en) begin
      tag_mem[wr_set] <= wr_tag;
      frm_mem[wr_set] <= wr_frm;
    end
  end

  // Read the set row on accept; capture the row being written for forwarding
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_vld_q  <= vld_mem[set_in];
      rd_tag_q  <= tag_mem[set_in];
      rd_frm_q  <= frm_mem[set_in];
      rd_ord_q  <= ord_mem[set_in];
      s1_op_q   <= req_i.operation;
      s1_set_q  <= set_in;
      s1_tag_q  <= page_in[TAG_W-1:0];
      s1_pp_q   <= req_i.physical_page;
      byp_vld_q <= new_vld;
      byp_tag_q <= new_tag;
      byp_frm_q <= new_frm;
      byp_ord_q <= new_ord;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        byp_q      <= wr_row_en && (s1_set_q == set_in);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Pick the current row contents
  always_comb begin
    row_vld = byp_q ? byp_vld_q : rd_vld_q;
    row_tag = byp_q ? byp_tag_q : rd_tag_q;
    row_frm = byp_q ? byp_frm_q : rd_frm_q;
    row_ord = byp_q ? byp_ord_q : rd_ord_q;
  end

  // Find the lowest matching way and the lowest free way
  always_comb begin
    hit_any = 1'b0;
    inv_any = 1'b0;
    hit_way = '0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_vld[w] && row_tag[w] == s1_tag_q) begin
        hit_any = 1'b1;
        hit_way = WIDX'(w);
      end
      if (!row_vld[w]) begin
        inv_any = 1'b1;
        inv_way = WIDX'(w);
      end
    end
    victim = inv_any ? inv_way : row_ord[WAYS-1];
  end

  // Move the touched way to the front of the order
  always_comb begin
    touch_way = (s1_op_q == OP_FILL) ? victim : hit_way;
    pos = WIDX'(WAYS - 1);
    for (int i = WAYS - 2; i >= 0; i--) begin
      if (row_ord[i] == touch_way) pos = WIDX'(i);
    end
    rec_ord    = row_ord;
    rec_ord[0] = touch_way;
    for (int i = 1; i < WAYS; i++) begin
      if (WIDX'(i) <= pos) rec_ord[i] = row_ord[i-1];
    end
  end

  // Row update and result
  always_comb begin
    new_vld     = row_vld;
    new_tag     = row_tag;
    new_frm     = row_frm;
    touch       = 1'b0;
    res_hit     = 1'b0;
    res_trans   = '0;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    flush_cnt_d = flush_cnt_q;
    case (s1_op_q)
      OP_LOOKUP: begin
        if (hit_any) begin
          touch     = 1'b1;
          res_hit   = 1'b1;
          res_trans = row_frm[hit_way];
          hit_cnt_d = hit_cnt_q + 1'b1;
        end else begin
          miss_cnt_d = miss_cnt_q + 1'b1;
        end
      end
      OP_FILL: begin
        touch           = 1'b1;
        new_vld[victim] = 1'b1;
        new_tag[victim] = s1_tag_q;
        new_frm[victim] = s1_pp_q;
      end
      OP_FLUSH_PAGE: begin
        flush_cnt_d = flush_cnt_q + 1'b1;
        if (hit_any) new_vld[hit_way] = 1'b0;
      end
      default: begin
        flush_cnt_d = flush_cnt_q + 1'b1;
      end
    endcase
    new_ord = touch ? rec_ord : row_ord;
  end

  // Counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      flush_cnt_q <= '0;
    end else if (s1_adv) begin
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      flush_cnt_q <= flush_cnt_d;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      rsp_hit_q   <= res_hit;
      rsp_trans_q <= res_trans;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.hit            = rsp_hit_q;
  assign rsp_o.translation    = rsp_trans_q;
  assign rsp_o.hits_so_far    = hit_cnt_q;
  assign rsp_o.misses_so_far  = miss_cnt_q;
  assign rsp_o.flushes_so_far = flush_cnt_q;

  // Clearing pass sequencer
  always_comb begin
    state_d   = state_q;
    clr_ord_d = clr_ord_q;
    swp_idx_d = swp_idx_q;
    unique case (state_q)
      ST_RUN: begin
        if (s1_adv && s1_op_q == OP_FLUSH_ALL) begin
          state_d   = ST_SWEEP;
          clr_ord_d = 1'b0;
          swp_idx_d = '0;
        end
      end
      ST_SWEEP: begin
        if (swp_idx_q == SET_IW'(SETS - 1)) begin
          state_d   = ST_RUN;
          clr_ord_d = 1'b0;
        end else begin
          swp_idx_d = swp_idx_q + 1'b1;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_SWEEP;
      clr_ord_q <= 1'b1;
      swp_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_ord_q <= clr_ord_d;
      swp_idx_q <= swp_idx_d;
    end
  end

  // Hit counter moves only after a lookup leaves stage 1
  a_hit_cnt_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_cnt_q != $past(hit_cnt_q) |-> $past(s1_adv && s1_op_q == OP_LOOKUP))
    else $error("hit counter changed without a lookup");

  // Flush counter moves only after a flush leaves stage 1
  a_flush_cnt_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_cnt_q != $past(flush_cnt_q) |->
      $past(s1_adv && (s1_op_q == OP_FLUSH_PAGE || s1_op_q == OP_FLUSH_ALL)))
    else $error("flush counter changed without a flush");

  // A full flush starts the clearing pass and blocks new requests
  a_flush_all_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_op_q == OP_FLUSH_ALL |=> state_q == ST_SWEEP && !req_i.ready)
    else $error("full flush did not start the clearing pass");

  // Stage 1 is empty during the clearing pass
  a_sweep_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SWEEP |-> !s1_valid_q)
    else $error("transaction in flight during clearing pass");

endmodule

// ----- bench/set_associative_tlb_lru_checker.sv -----
module set_associative_tlb_lru_checker #(
  parameter int unsigned LOG_SETS = 4,
  parameter int unsigned WAYS     = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  stlb_pkg::lps_t      cfg_wdata_i,
  stlb_req_if                 req_i,
  stlb_rsp_if                 rsp_i,
  output int unsigned         pending_o,
  output int unsigned         mismatch_count_o
);
  import stlb_pkg::*;

  localparam int unsigned SETS = 1 << LOG_SETS;

  typedef struct packed {
    logic  hit;
    addr_t translation;
    cnt_t  hits;
    cnt_t  misses;
    cnt_t  flushes;
  } tlb_result_t;

  // Shadow copy of the TLB contents, recency lists and counters
  logic        way_valid  [SETS][WAYS];
  tag_t        way_tag    [SETS][WAYS];
  addr_t       way_frame  [SETS][WAYS];
  int unsigned lru_list   [SETS][WAYS];
  cnt_t        hit_total;
  cnt_t        miss_total;
  cnt_t        flush_total;
  lps_t        page_size_log;

  tlb_result_t expected_results [$];

  // Return the lowest valid way of the set holding the tag, or -1
  function automatic int match_way(int unsigned set_idx, tag_t tag);
    for (int w = 0; w < WAYS; w++) begin
      if (way_valid[set_idx][w] && way_tag[set_idx][w] == tag) return w;
    end
    return -1;
  endfunction

  // Move a way to the head of its set's recency list
  function automatic void promote_way(int unsigned set_idx, int unsigned way);
    int unsigned pos;
    pos = 0;
    while (pos + 1 < WAYS && lru_list[set_idx][pos] != way) pos++;
    while (pos > 0) begin
      lru_list[set_idx][pos] = lru_list[set_idx][pos-1];
      pos--;
    end
    lru_list[set_idx][0] = way;
  endfunction

  // Apply one request transaction to the shadow state and return its response
  function automatic tlb_result_t translate_request(op_e op, addr_t va, addr_t pp);
    int unsigned shift;
    int unsigned set_idx;
    int unsigned victim;
    int          way;
    addr_t       page;
    tag_t        tag;
    tlb_result_t res;
    shift   = (page_size_log < LPS_MIN) ? LPS_MIN :
              (page_size_log > LPS_MAX) ? LPS_MAX : page_size_log;
    page    = va >> shift;
    set_idx = page & (SETS - 1);
    tag     = page[TAG_W-1:0];
    res     = '0;
    case (op)
      OP_LOOKUP: begin
        way = match_way(set_idx, tag);
        if (way >= 0) begin
          res.hit         = 1'b1;
          res.translation = way_frame[set_idx][way];
          hit_total++;
          promote_way(set_idx, way);
        end else begin
          miss_total++;
        end
      end
      OP_FILL: begin
        victim = 0;
        while (victim < WAYS && way_valid[set_idx][victim]) victim++;
        if (victim == WAYS) victim = lru_list[set_idx][WAYS-1];
        way_tag[set_idx][victim]   = tag;
        way_frame[set_idx][victim] = pp;
        way_valid[set_idx][victim] = 1'b1;
        promote_way(set_idx, victim);
      end
      OP_FLUSH_PAGE: begin
        flush_total++;
        way = match_way(set_idx, tag);
        if (way >= 0) way_valid[set_idx][way] = 1'b0;
      end
      default: begin
        flush_total++;
        foreach (way_valid[s, w]) way_valid[s][w] = 1'b0;
      end
    endcase
    res.hits    = hit_total;
    res.misses  = miss_total;
    res.flushes = flush_total;
    return res;
  endfunction

  task automatic report_mismatch(string what, tlb_result_t exp_res, tlb_result_t act_res);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected hit=%0b trans=%h hits=%0d misses=%0d flushes=%0d",
               exp_res.hit, exp_res.translation, exp_res.hits, exp_res.misses,
               exp_res.flushes);
      $display("  actual   hit=%0b trans=%h hits=%0d misses=%0d flushes=%0d",
               act_res.hit, act_res.translation, act_res.hits, act_res.misses,
               act_res.flushes);
    end
  endtask

  initial mismatch_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    tlb_result_t act_res;
    tlb_result_t exp_res;
    if (!rst_ni) begin
      // Restore the reset state
      foreach (way_valid[s, w]) begin
        way_valid[s][w] = 1'b0;
        lru_list[s][w]  = w;
      end
      hit_total     = '0;
      miss_total    = '0;
      flush_total   = '0;
      page_size_log = LPS_RESET;
      expected_results.delete();
    end else begin
      // Check a response transaction against the oldest expectation
      if (rsp_i.valid && rsp_i.ready) begin
        act_res = {rsp_i.hit, rsp_i.translation, rsp_i.hits_so_far,
                   rsp_i.misses_so_far, rsp_i.flushes_so_far};
        if (expected_results.size() == 0) begin
          report_mismatch("response with no request outstanding", '0, act_res);
        end else begin
          exp_res = expected_results.pop_front();
          if (act_res !== exp_res) report_mismatch("response mismatch", exp_res, act_res);
        end
      end
      // Predict the response of an accepted request transaction and queue it
      if (req_i.valid && req_i.ready) begin
        exp_res = translate_request(req_i.operation, req_i.virtual_address,
                                    req_i.physical_page);
        expected_results.insert(expected_results.size(), exp_res);
      end
      if (cfg_we_i) page_size_log = cfg_wdata_i;
    end
    pending_o = expected_results.size();
  end

endmodule

// ----- bench/set_associative_tlb_lru_tb.sv -----
module set_associative_tlb_lru_tb;
  import stlb_pkg::*;

  localparam int unsigned LOG_SETS  = 4;
  localparam int unsigned WAYS      = 2;
  localparam int unsigned POOL_SIZE = 12;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  lps_t        cfg_wdata;
  logic        steady;
  int unsigned shift_now;
  int unsigned pending;
  int unsigned mismatches;
  addr_t       page_pool [POOL_SIZE];

  stlb_req_if req_if ();
  stlb_rsp_if rsp_if ();

  set_associative_tlb_lru #(
    .LOG_SETS (LOG_SETS),
    .WAYS     (WAYS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  set_associative_tlb_lru_checker #(
    .LOG_SETS (LOG_SETS),
    .WAYS     (WAYS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .pending_o        (pending),
    .mismatch_count_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the response side at random unless in a steady stretch
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready = steady || ($urandom_range(99) >= 11);
    end
  end

  // Abort a hung run
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // Present one request transaction and hold it until accepted
  task automatic send_request(op_e op, addr_t va, addr_t pp);
    while (!steady && $urandom_range(99) < 11) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid           = 1'b1;
    req_if.operation       = op;
    req_if.virtual_address = va;
    req_if.physical_page   = pp;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  // Drain all responses, then let any clearing pass finish
  task automatic wait_idle();
    req_if.valid = 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat ((1 << LOG_SETS) + 4) @(negedge clk_i);
  endtask

  task automatic write_page_size(lps_t value);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    shift_now = (value < LPS_MIN) ? LPS_MIN : (value > LPS_MAX) ? LPS_MAX : value;
  endtask

  // Draw an address, mostly from a small set of pages crowded into a few sets
  function automatic addr_t pick_address();
    addr_t page;
    if ($urandom_range(99) < 20) return $urandom;
    page = page_pool[$urandom_range(POOL_SIZE-1)];
    return (page << shift_now) | ($urandom & ((32'd1 << shift_now) - 1));
  endfunction

  task automatic run_random(int unsigned count);
    int unsigned pick;
    op_e         op;
    for (int i = 0; i < POOL_SIZE; i++) begin
      page_pool[i] = $urandom & 32'h00FF_FFFF;
      if (i < 8) page_pool[i][LOG_SETS-1:0] = LOG_SETS'(i % 3);
    end
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 50)      op = OP_LOOKUP;
      else if (pick < 80) op = OP_FILL;
      else if (pick < 96) op = OP_FLUSH_PAGE;
      else                op = OP_FLUSH_ALL;
      send_request(op, pick_address(), $urandom);
    end
  endtask

  initial begin
    // Drive every input to a known value
    rst_ni                 = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = LPS_RESET;
    steady                 = 1'b0;
    shift_now              = LPS_RESET;
    req_if.valid           = 1'b0;
    req_if.operation       = OP_LOOKUP;
    req_if.virtual_address = '0;
    req_if.physical_page   = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: hits, misses, LRU eviction, duplicate fills and both flushes
    send_request(OP_LOOKUP,     32'h0000_0000, 32'h0000_0000);
    send_request(OP_FILL,       32'h0000_0ABC, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP,     32'h0000_0FFF, 32'h0000_0000);
    send_request(OP_FILL,       32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_LOOKUP,     32'hFFFF_F000, 32'hFFFF_FFFF);
    send_request(OP_FILL,       32'h0001_0000, 32'h1234_5678);
    send_request(OP_LOOKUP,     32'h0000_0000, 32'h0000_0000);
    send_request(OP_FILL,       32'h0002_0000, 32'h8765_4321);
    send_request(OP_LOOKUP,     32'h0001_0000, 32'h0000_0000);
    send_request(OP_LOOKUP,     32'h0002_0123, 32'h0000_0000);
    send_request(OP_FILL,       32'h0003_0000, 32'hA5A5_A5A5);
    send_request(OP_FILL,       32'h0003_0000, 32'h5A5A_5A5A);
    send_request(OP_LOOKUP,     32'h0003_0000, 32'h0000_0000);
    send_request(OP_FLUSH_PAGE, 32'h0003_0FFF, 32'h0000_0000);
    send_request(OP_LOOKUP,     32'h0003_0000, 32'h0000_0000);
    send_request(OP_FLUSH_PAGE, 32'h7777_7000, 32'h0000_0000);
    send_request(OP_FLUSH_ALL,  32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP,     32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_LOOKUP,     32'h0003_0000, 32'h0000_0000);
    send_request(OP_FILL,       32'h8000_0000, 32'h8000_0001);
    send_request(OP_LOOKUP,     32'h8000_0FFF, 32'h0000_0000);
    run_random(230);

    // Sweep page sizes, including values that saturate
    write_page_size(LPS_MAX);
    steady = 1'b1;
    run_random(230);
    steady = 1'b0;
    write_page_size(LPS_MIN);
    run_random(230);
    write_page_size(5'd31);
    run_random(230);
    write_page_size(5'd0);
    run_random(230);
    write_page_size(lps_t'($urandom_range(9, 15)));
    run_random(230);

    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
